>>> rtl/btl_pkg.sv
// ----------------------------------------------------------------------------
// btl_pkg
// Shared constants, link types and index helpers for the bakery ticket lock.
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int THREADS     = 8;
  localparam int TICKET_BITS = 16;

  localparam int IDX_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int ID_W   = 3;
  localparam int CFG_W  = 4;
  localparam int CNT_W  = $clog2(THREADS + 1);
  localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int DATA_W = 8;

  localparam logic [CFG_W-1:0]       CFG_RESET  = CFG_W'(8);
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  localparam logic FUNC_REQ = 1'b0;
  localparam logic FUNC_REL = 1'b1;

  typedef logic [TICKET_BITS-1:0] ticket_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // running max and running best as they travel down the chain
  typedef struct packed {
    logic    v;
    ticket_t max_tkt;
    logic    found;
    ticket_t best_tkt;
    idx_t    best_id;
  } link_t;

  typedef struct packed {
    logic excl;
    idx_t id;
  } cmd_t;

  typedef struct packed {
    logic    we;
    idx_t    id;
    logic    flag;
    ticket_t ticket;
  } upd_t;

  function automatic idx_t to_idx(input logic [ID_W-1:0] id);
    logic [ID_W+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, id};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] to_id(input idx_t idx);
    logic [ID_W+IDX_W-1:0] w;
    w = {{ID_W{1'b0}}, idx};
    return w[ID_W-1:0];
  endfunction

endpackage

>>> rtl/btl_cell.sv
// ----------------------------------------------------------------------------
// btl_cell
// One thread's flag and ticket; folds them into the passing max/min link.
// ----------------------------------------------------------------------------
module btl_cell (
  input  logic           clk,
  input  logic           rst,
  input  btl_pkg::idx_t  idx,
  input  btl_pkg::cmd_t  cmd,
  input  btl_pkg::upd_t  upd,
  input  btl_pkg::link_t link_in,
  output btl_pkg::link_t link_out,
  output logic           flag
);

  btl_pkg::ticket_t ticket;
  btl_pkg::link_t   link_next;
  logic             use_me;

  always_comb begin
    use_me    = flag && (ticket != '0) && !(cmd.excl && (cmd.id == idx));
    link_next = link_in;
    if (ticket > link_in.max_tkt) begin
      link_next.max_tkt = ticket;
    end
    if (use_me && (!link_in.found || (ticket < link_in.best_tkt))) begin
      link_next.found    = 1'b1;
      link_next.best_tkt = ticket;
      link_next.best_id  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag     <= 1'b0;
      ticket   <= '0;
      link_out <= '0;
    end else begin
      link_out <= link_next;
      if (upd.we && (upd.id == idx)) begin
        flag <= upd.flag;
        if (upd.flag) begin
          ticket <= upd.ticket;
        end
      end
    end
  end

endmodule

>>> rtl/bakery_ticket_lock_arbiter.sv
// ----------------------------------------------------------------------------
// bakery_ticket_lock_arbiter
// Ticket lock arbiter: request/release events in, current owner out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one event per request: s_tuser is the kind (0 lock, 1 release),
//   s_tdata[2:0] the thread id. m_* returns one result per event: the owner
//   (valid flag and id) in m_tdata and the ignored flag in m_tuser.
//   cfg_we/cfg_wdata set the active thread count; write it only when idle.
//   Each thread is a cell in a chain; one sweep token walks the chain, one
//   cell per cycle, gathering the largest ticket and the smallest flagged
//   (ticket, id) pair. The requesting thread is merged at the chain's end.
//   An accepted event passes the launch register, each cell's link register,
//   the fin register (S_DONE) and the output register. Events are taken one
//   at a time: the next is accepted only once the arbiter is back in S_IDLE.
//   A new event is accepted while a result still waits on m_*; its own
//   result then holds at the chain end until the output register is free.
//   Reset clears all flags and tickets, sets the active count to eight and
//   empties the output register.
// ----------------------------------------------------------------------------
module bakery_ticket_lock_arbiter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [btl_pkg::DATA_W-1:0] s_tdata,   // [2:0] thread_id
  input  logic                       s_tuser,   // [0] func
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [btl_pkg::DATA_W-1:0] m_tdata,   // [0] owner_valid, [3:1] owner_id
  output logic                       m_tuser,   // [0] ignored
  input  logic                       cfg_we,
  input  logic [btl_pkg::CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

  state_t                     state;
  logic [btl_pkg::CFG_W-1:0]  active;
  logic                       launch;
  btl_pkg::cmd_t              cmd;
  logic                       func_r;
  logic                       ign_r;
  btl_pkg::link_t             fin;
  btl_pkg::link_t             links [btl_pkg::THREADS+1];
  logic [btl_pkg::THREADS-1:0] flags;
  btl_pkg::upd_t              upd;

  logic [btl_pkg::ID_W-1:0]   in_id;
  btl_pkg::idx_t              in_idx;
  logic [btl_pkg::CMP_W-1:0]  eff;
  logic                       in_range;
  logic                       in_ign;
  logic                       accept;
  logic                       out_free;
  logic                       req;
  btl_pkg::ticket_t           t_new;
  logic                       cand;
  logic                       own_v;
  btl_pkg::idx_t              own_idx;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_id    = s_tdata[btl_pkg::ID_W-1:0];
  assign in_idx   = btl_pkg::to_idx(in_id);
  assign eff      = (btl_pkg::CMP_W'(active) > btl_pkg::CMP_W'(btl_pkg::THREADS)) ?
                    btl_pkg::CMP_W'(btl_pkg::THREADS) : btl_pkg::CMP_W'(active);
  assign in_range = btl_pkg::CMP_W'(in_id) < eff;
  assign in_ign   = !in_range || ((s_tuser == btl_pkg::FUNC_REQ) && flags[in_idx]);

  assign links[0] = '{v: launch, max_tkt: '0, found: 1'b0, best_tkt: '0, best_id: '0};

  for (genvar k = 0; k < btl_pkg::THREADS; k++) begin : g_cell
    btl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (btl_pkg::IDX_W'(k)),
      .cmd      (cmd),
      .upd      (upd),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .flag     (flags[k])
    );
  end

  // merge the requester's new ticket with the best of the others
  always_comb begin
    req     = !ign_r && (func_r == btl_pkg::FUNC_REQ);
    t_new   = (fin.max_tkt == btl_pkg::TICKET_MAX) ? fin.max_tkt
                                                   : fin.max_tkt + 1'b1;
    cand    = req && (!fin.found || (t_new < fin.best_tkt) ||
                      ((t_new == fin.best_tkt) && (cmd.id < fin.best_id)));
    own_v   = fin.found || req;
    own_idx = cand ? cmd.id : (fin.found ? fin.best_id : '0);
    upd.we     = (state == S_DONE) && out_free && !ign_r;
    upd.id     = cmd.id;
    upd.flag   = (func_r == btl_pkg::FUNC_REQ);
    upd.ticket = t_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      active   <= btl_pkg::CFG_RESET;
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      launch <= accept;
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd.excl <= !in_ign;
            cmd.id   <= in_idx;
            func_r   <= s_tuser;
            ign_r    <= in_ign;
            state    <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (links[btl_pkg::THREADS].v) begin
            fin   <= links[btl_pkg::THREADS];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(btl_pkg::DATA_W-btl_pkg::ID_W-1){1'b0}},
                         btl_pkg::to_id(own_idx), own_v};
            m_tuser  <= ign_r;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/btl_checker.sv
// ----------------------------------------------------------------------------
// btl_checker
// Port-level checks for the bakery ticket lock arbiter, bound to the top.
// ----------------------------------------------------------------------------
module btl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [btl_pkg::DATA_W-1:0] m_tdata,
  input logic                       m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_no_owner_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[3:1] == 3'd0))
    else $error("owner id set without owner");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while sweep in progress");

endmodule

bind bakery_ticket_lock_arbiter btl_checker u_btl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/bakery_ticket_lock_arbiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bakery_ticket_lock_arbiter_tb
// Drives lock and release requests into the arbiter and checks every owner
// report against a bakery-ordering predictor kept in the bench. A directed
// opening covers ignored ids, repeat requests, unflagged releases, shrunk,
// zero and oversized active counts. Random phases follow under several
// active counts, then every thread is released and a short directed run
// and a last random phase close the test. The sender idles in bursts and
// the receiver stalls on a random pattern.
// ----------------------------------------------------------------------------
module bakery_ticket_lock_arbiter_tb;

  localparam int SETTLE_CYCLES = btl_pkg::THREADS + 4;

  typedef struct packed {
    logic                     func;
    logic [btl_pkg::ID_W-1:0] thread;
  } lock_event_t;

  typedef struct packed {
    logic                     owner_valid;
    logic [btl_pkg::ID_W-1:0] owner_id;
    logic                     ignored;
  } owner_report_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [btl_pkg::DATA_W-1:0] s_tdata   = '0;
  logic                       s_tuser   = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [btl_pkg::DATA_W-1:0] m_tdata;
  logic                       m_tuser;
  logic                       cfg_we    = 1'b0;
  logic [btl_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // predictor state
  logic                      waiting [btl_pkg::THREADS];
  btl_pkg::ticket_t          tickets [btl_pkg::THREADS];
  logic [btl_pkg::CFG_W-1:0] active_cnt;

  lock_event_t   pending_events[$];
  owner_report_t owner_queue[$];
  lock_event_t   launch_ev;
  logic          in_flight   = 1'b0;
  int            burst_left  = 0;
  int            gap_left    = 0;
  logic [31:0]   stall_bits  = '0;
  int            stall_mode  = 0;
  int            stall_left  = 0;
  int            fail_count  = 0;
  owner_report_t got;
  owner_report_t want;

  bakery_ticket_lock_arbiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic owner_report_t arbitrate(input logic func,
                                              input logic [btl_pkg::ID_W-1:0] id);
    int               eff;
    btl_pkg::ticket_t top;
    btl_pkg::ticket_t best_tkt;
    owner_report_t    r;
    r = '0;
    eff = (int'(active_cnt) > btl_pkg::THREADS) ? btl_pkg::THREADS : int'(active_cnt);
    if (int'(id) >= eff) begin
      r.ignored = 1'b1;
    end else if (func == btl_pkg::FUNC_REQ) begin
      if (waiting[id]) begin
        r.ignored = 1'b1;
      end else begin
        top = '0;
        for (int i = 0; i < btl_pkg::THREADS; i++)
          if (tickets[i] > top) top = tickets[i];
        waiting[id] = 1'b1;
        tickets[id] = (top == btl_pkg::TICKET_MAX) ? btl_pkg::TICKET_MAX : top + 1'b1;
      end
    end else begin
      waiting[id] = 1'b0;
    end
    best_tkt = '0;
    for (int i = 0; i < btl_pkg::THREADS; i++) begin
      if (waiting[i] && tickets[i] != '0 && (!r.owner_valid || tickets[i] < best_tkt)) begin
        r.owner_valid = 1'b1;
        best_tkt      = tickets[i];
        r.owner_id    = btl_pkg::ID_W'(i);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic queue_event(input logic func, input int id);
    pending_events.push_back('{func, btl_pkg::ID_W'(id)});
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_flight || owner_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_threads(input logic [btl_pkg::CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    active_cnt  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [btl_pkg::CFG_W-1:0] value, input int count);
    logic flagged [btl_pkg::THREADS];
    int   eff;
    int   id;
    logic func;
    set_active_threads(value);
    eff = (int'(value) > btl_pkg::THREADS) ? btl_pkg::THREADS : int'(value);
    for (int i = 0; i < btl_pkg::THREADS; i++) flagged[i] = waiting[i];
    for (int k = 0; k < count; k++) begin
      if (eff == 0 || $urandom_range(0, 9) == 0) id = $urandom_range(0, btl_pkg::THREADS - 1);
      else id = $urandom_range(0, eff - 1);
      if (id < eff && flagged[id])
        func = ($urandom_range(0, 7) == 0) ? btl_pkg::FUNC_REQ : btl_pkg::FUNC_REL;
      else
        func = ($urandom_range(0, 7) == 0) ? btl_pkg::FUNC_REL : btl_pkg::FUNC_REQ;
      if (id < eff) flagged[id] = (func == btl_pkg::FUNC_REQ);
      queue_event(func, id);
    end
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        owner_queue.push_back(arbitrate(s_tuser, s_tdata[btl_pkg::ID_W-1:0]));
        in_flight = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          launch_ev  = pending_events.pop_front();
          in_flight  = 1'b1;
          s_tvalid  <= 1'b1;
          s_tdata   <= btl_pkg::DATA_W'(launch_ev.thread);
          s_tuser   <= launch_ev.func;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall on a random bit pattern or not at all, mode and pattern refreshed once all its bits are used
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_bits = $urandom;
        stall_mode = $urandom_range(0, 3);
        stall_left = 32;
        if (stall_mode == 3) stall_bits = stall_bits & $urandom;
      end
      stall_left--;
      m_tready <= stall_mode == 0 || stall_bits[stall_left];
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.owner_valid = m_tdata[0];
      got.owner_id    = m_tdata[btl_pkg::ID_W:1];
      got.ignored     = m_tuser;
      if (owner_queue.size() == 0) begin
        report_mismatch("owner report with no request outstanding");
      end else begin
        want = owner_queue.pop_front();
        if (got.owner_valid != want.owner_valid)
          report_mismatch($sformatf("owner_valid %0d, expected %0d",
                                    got.owner_valid, want.owner_valid));
        if (got.owner_id != want.owner_id)
          report_mismatch($sformatf("owner_id %0d, expected %0d",
                                    got.owner_id, want.owner_id));
        if (got.ignored != want.ignored)
          report_mismatch($sformatf("ignored %0d, expected %0d", got.ignored, want.ignored));
      end
    end
  end

  initial begin
    for (int i = 0; i < btl_pkg::THREADS; i++) begin
      waiting[i] = 1'b0;
      tickets[i] = '0;
    end
    active_cnt = btl_pkg::CFG_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: full count after reset
    queue_event(btl_pkg::FUNC_REL, 0);
    queue_event(btl_pkg::FUNC_REQ, 0);
    queue_event(btl_pkg::FUNC_REQ, 0);
    queue_event(btl_pkg::FUNC_REQ, 7);
    queue_event(btl_pkg::FUNC_REQ, 3);
    queue_event(btl_pkg::FUNC_REL, 0);
    queue_event(btl_pkg::FUNC_REQ, 0);
    queue_event(btl_pkg::FUNC_REL, 7);
    // shrunk count: thread 3 keeps its place
    set_active_threads(4'd3);
    queue_event(btl_pkg::FUNC_REQ, 5);
    queue_event(btl_pkg::FUNC_REQ, 1);
    queue_event(btl_pkg::FUNC_REL, 3);
    // no active threads
    set_active_threads(4'd0);
    queue_event(btl_pkg::FUNC_REQ, 0);
    queue_event(btl_pkg::FUNC_REL, 1);
    // oversized count acts as full
    set_active_threads(4'd15);
    queue_event(btl_pkg::FUNC_REQ, 7);
    queue_event(btl_pkg::FUNC_REL, 3);
    queue_event(btl_pkg::FUNC_REQ, 4);
    queue_event(btl_pkg::FUNC_REQ, 6);
    queue_event(btl_pkg::FUNC_REQ, 2);
    set_active_threads(4'd1);
    queue_event(btl_pkg::FUNC_REQ, 1);
    queue_event(btl_pkg::FUNC_REL, 0);
    queue_event(btl_pkg::FUNC_REQ, 0);

    run_random_phase(4'd8, 90);
    run_random_phase(4'd1, 90);
    run_random_phase(4'd4, 90);
    run_random_phase(4'd15, 90);
    run_random_phase(btl_pkg::CFG_W'($urandom_range(1, 8)), 90);
    run_random_phase(4'd2, 90);
    run_random_phase(4'd7, 90);
    run_random_phase(4'd8, 90);

    // release every thread, then a short directed run
    for (int i = 0; i < btl_pkg::THREADS; i++) queue_event(btl_pkg::FUNC_REL, i);
    wait_idle();
    queue_event(btl_pkg::FUNC_REQ, 5);
    queue_event(btl_pkg::FUNC_REQ, 2);
    queue_event(btl_pkg::FUNC_REQ, 6);
    queue_event(btl_pkg::FUNC_REL, 2);
    queue_event(btl_pkg::FUNC_REL, 5);
    queue_event(btl_pkg::FUNC_REQ, 0);
    queue_event(btl_pkg::FUNC_REQ, 2);
    run_random_phase(4'd8, 100);
    wait_idle();

    if (fail_count == 0) begin
      $display("bakery_ticket_lock_arbiter_tb passed");
    end else begin
      $display("bakery_ticket_lock_arbiter_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bakery_ticket_lock_arbiter_tb failed");
    $finish;
  end

endmodule
